@@ rtl/tcr_pkg.sv @@
`default_nettype none
package tcr_pkg;

  // Default width of one tensor dimension (channels, height or width).
  localparam int DIM_BITS_DEF = 12;

  // Width of the Q8.16 scale ratio register.
  localparam int SCALE_W = 24;

  // Depth of the queue between the classifying front and the rescaling back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_IN_SHAPE    = 3'd1,
    CFG_OUT_SHAPE   = 3'd2,
    CFG_CROP_OFFSET = 3'd3,
    CFG_SCALE_RATIO = 3'd4
  } tcr_cfg_idx_t;

  // Crop modes.
  typedef enum logic [1:0] {
    MODE_CENTRE      = 2'd0,
    MODE_OFFSET_CHK  = 2'd1,
    MODE_CHAN_OFFSET = 2'd2,
    MODE_OFFSET_UNCH = 2'd3
  } tcr_mode_t;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  // Input item.
  typedef struct packed {
    logic signed [7:0] sample;
    logic              start_req;
  } tcr_in_t;

  // Result item.
  typedef struct packed {
    logic signed [7:0] cropped;
    logic              end_of_window;
  } tcr_out_t;

  // Queue entry: a kept element still to be rescaled.
  typedef struct packed {
    logic signed [7:0] sample;
    logic              last;
  } tcr_qent_t;

endpackage
`default_nettype wire

@@ rtl/tcr_front.sv @@
`default_nettype none
module tcr_front
  import tcr_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tcr_in_t               in_data,
  input  logic [1:0]            mode,
  input  logic [3*DIM_BITS-1:0] in_shape,
  input  logic [3*DIM_BITS-1:0] out_shape,
  input  logic [3*DIM_BITS-1:0] crop_offset,
  input  logic                  q_full,
  output logic                  push,
  output tcr_qent_t             push_data
);

  localparam int E = DIM_BITS + 1;

  logic [DIM_BITS-1:0] col_r, row_r, chan_r;
  logic [DIM_BITS-1:0] col_nxt, row_nxt, chan_nxt;
  logic [DIM_BITS-1:0] col_cur, row_cur, chan_cur;

  logic [DIM_BITS-1:0] iw, ih, ic, ow, oh, oc;
  logic [DIM_BITS-1:0] offw, offh, offc;
  logic [E-1:0]        endw, endh, endc, sumw, sumh, sumc;
  logic                fits0, fits, kept, last, accept;
  tcr_mode_t           mode_e;

  assign iw = in_shape[DIM_BITS-1:0];
  assign ih = in_shape[2*DIM_BITS-1:DIM_BITS];
  assign ic = in_shape[3*DIM_BITS-1:2*DIM_BITS];
  assign ow = out_shape[DIM_BITS-1:0];
  assign oh = out_shape[2*DIM_BITS-1:DIM_BITS];
  assign oc = out_shape[3*DIM_BITS-1:2*DIM_BITS];

  assign mode_e = tcr_mode_t'(mode);
  assign fits0  = (oh <= ih) && (ow <= iw);

  // Window origin for the current mode.
  always_comb begin
    offw = crop_offset[DIM_BITS-1:0];
    offh = crop_offset[2*DIM_BITS-1:DIM_BITS];
    offc = '0;
    fits = 1'b1;
    unique case (mode_e)
      MODE_CENTRE: begin
        offw = fits0 ? DIM_BITS'((iw - ow) >> 1) : '0;
        offh = fits0 ? DIM_BITS'((ih - oh) >> 1) : '0;
        fits = fits0;
      end
      MODE_OFFSET_CHK: begin
        fits = ({1'b0, offh} + {1'b0, oh} <= {1'b0, ih}) &&
               ({1'b0, offw} + {1'b0, ow} <= {1'b0, iw});
      end
      MODE_CHAN_OFFSET: begin
        offc = crop_offset[3*DIM_BITS-1:2*DIM_BITS];
      end
      default: begin
      end
    endcase
  end

  // Window end, clipped to the input size.
  assign sumw = {1'b0, offw} + {1'b0, ow};
  assign sumh = {1'b0, offh} + {1'b0, oh};
  assign sumc = {1'b0, offc} + {1'b0, oc};
  assign endw = (sumw < {1'b0, iw}) ? sumw : {1'b0, iw};
  assign endh = (sumh < {1'b0, ih}) ? sumh : {1'b0, ih};
  assign endc = (sumc < {1'b0, ic}) ? sumc : {1'b0, ic};

  // A start mark places this element at the image origin.
  assign col_cur  = in_data.start_req ? '0 : col_r;
  assign row_cur  = in_data.start_req ? '0 : row_r;
  assign chan_cur = in_data.start_req ? '0 : chan_r;

  assign kept = fits &&
                (col_cur >= offw)  && ({1'b0, col_cur}  < endw) &&
                (row_cur >= offh)  && ({1'b0, row_cur}  < endh) &&
                (chan_cur >= offc) && ({1'b0, chan_cur} < endc);

  assign last = ({1'b0, col_cur}  == endw - E'(1)) &&
                ({1'b0, row_cur}  == endh - E'(1)) &&
                ({1'b0, chan_cur} == endc - E'(1));

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign push             = accept && kept;
  assign push_data.sample = in_data.sample;
  assign push_data.last   = last;

  // Raster advance: column, then row, then channel, each wrapping at its size.
  always_comb begin
    col_nxt  = col_cur;
    row_nxt  = row_cur;
    chan_nxt = chan_cur;
    if ({1'b0, col_cur} + E'(1) >= {1'b0, iw}) begin
      col_nxt = '0;
      if ({1'b0, row_cur} + E'(1) >= {1'b0, ih}) begin
        row_nxt = '0;
        if ({1'b0, chan_cur} + E'(1) >= {1'b0, ic}) begin
          chan_nxt = '0;
        end else begin
          chan_nxt = chan_cur + DIM_BITS'(1);
        end
      end else begin
        row_nxt = row_cur + DIM_BITS'(1);
      end
    end else begin
      col_nxt = col_cur + DIM_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      chan_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      chan_r <= chan_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tcr_queue.sv @@
`default_nettype none
module tcr_queue
  import tcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tcr_qent_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output tcr_qent_t head
);

  tcr_qent_t       mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full  = (count_r == Q_CW'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + Q_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tcr_back.sv @@
`default_nettype none
module tcr_back
  import tcr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SCALE_W-1:0] scale_ratio,
  input  logic               q_empty,
  input  tcr_qent_t          q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tcr_out_t           out_data
);

  // Stage one holds the product, stage two the saturated result.
  logic signed [32:0]      prod_r, prod_nxt, adj;
  logic                    last1_r, v1_r;
  logic                    out_valid_r;
  tcr_out_t                out_data_r, out_data_nxt;
  logic signed [16:0]      quo;
  logic signed [7:0]       samp_s;
  logic signed [SCALE_W:0] ratio_s;
  logic                    s2_free, s1_free;

  assign s2_free = !out_valid_r || out_ready;
  assign s1_free = !v1_r || s2_free;
  assign pop     = s1_free && !q_empty;

  assign samp_s   = q_head.sample;
  assign ratio_s  = $signed({1'b0, scale_ratio});
  assign prod_nxt = samp_s * ratio_s;

  // Truncation toward zero: bias negative products before the arithmetic shift.
  assign adj = prod_r + (prod_r[32] ? 33'sd65535 : 33'sd0);
  assign quo = adj[32:16];

  always_comb begin
    out_data_nxt.end_of_window = last1_r;
    if (quo > 17'sd127) begin
      out_data_nxt.cropped = 8'sd127;
    end else if (quo < -17'sd128) begin
      out_data_nxt.cropped = -8'sd128;
    end else begin
      out_data_nxt.cropped = quo[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prod_r  <= prod_nxt;
      last1_r <= q_head.last;
    end
    if (s2_free && v1_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        v1_r <= !q_empty;
      end
      if (s2_free) begin
        out_valid_r <= v1_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ rtl/tensor_crop_rescale_int8.sv @@
`default_nettype none
// Streaming crop of an int8 tensor with requantization. Elements enter one per item in
// channel, row, column order; an item with start_req set restarts the position counters
// at the image origin. Each element whose position lies inside the crop window leaves
// as one result item, multiplied by the unsigned Q8.16 scale_ratio, truncated toward
// zero and saturated to int8; elements outside the window produce no result. The block
// takes one item per clock cycle while the queue has room: the front classifies an item
// in the cycle it is accepted, a four-entry queue decouples it from the back, and the
// back registers the 8 x 24 bit product and then the shifted, saturated result.
// in_ready falls only when the queue is full. Configuration registers are written
// through cfg_we, cfg_index and cfg_wdata; the user writes them only while the block is
// idle, which the block does not enforce. Writes to unknown indexes are ignored.
module tensor_crop_rescale_int8
  import tcr_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tcr_in_t       in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tcr_out_t      out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [((3*DIM_BITS > SCALE_W) ? 3*DIM_BITS : SCALE_W)-1:0] cfg_wdata
);

  localparam int SHAPE_W = 3 * DIM_BITS;

  // Configuration registers. Shapes and offsets pack channels, height and width,
  // channels in the top field.
  logic [1:0]         mode_r;
  logic [SHAPE_W-1:0] in_shape_r;
  logic [SHAPE_W-1:0] out_shape_r;
  logic [SHAPE_W-1:0] crop_offset_r;
  logic [SCALE_W-1:0] scale_ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_CENTRE;
      in_shape_r    <= '0;
      out_shape_r   <= '0;
      crop_offset_r <= '0;
      scale_ratio_r <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (tcr_cfg_idx_t'(cfg_index))
        CFG_MODE:        mode_r        <= cfg_wdata[1:0];
        CFG_IN_SHAPE:    in_shape_r    <= cfg_wdata[SHAPE_W-1:0];
        CFG_OUT_SHAPE:   out_shape_r   <= cfg_wdata[SHAPE_W-1:0];
        CFG_CROP_OFFSET: crop_offset_r <= cfg_wdata[SHAPE_W-1:0];
        CFG_SCALE_RATIO: scale_ratio_r <= cfg_wdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front decides whether an element is kept and whether it closes the window.
  logic      push, q_full, q_empty, pop;
  tcr_qent_t push_data, q_head;

  tcr_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .mode        (mode_r),
    .in_shape    (in_shape_r),
    .out_shape   (out_shape_r),
    .crop_offset (crop_offset_r),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  // Kept elements wait here so that an output stall does not stop the counters at once.
  tcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // The back rescales and holds the result until the consumer takes it.
  tcr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .scale_ratio (scale_ratio_r),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

@@ rtl/tcr_checker.sv @@
`default_nettype none
module tcr_checker
  import tcr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input tcr_out_t out_data
);

  // A result that is not taken stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item dropped or changed while stalled");

  // Reset empties the result stage.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Reset empties the queue, so the input side is ready at once.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind tensor_crop_rescale_int8 tcr_checker u_tcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

@@ tb/sv/tensor_crop_rescale_int8_test.sv @@
module tensor_crop_rescale_int8_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcr_pkg::*;

  // Register widths as the block sees them with its default dimension width.
  localparam int DIMW    = DIM_BITS_DEF;
  localparam int SHAPE_W = 3 * DIMW;
  localparam int CFG_W   = (SHAPE_W > SCALE_W) ? SHAPE_W : SCALE_W;

  // The slowest correct run stays far below this: roughly a thousand items, each with at
  // most one short sender gap and one short receiver stall, plus one long hold-off.
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n;

  logic                 in_valid;
  logic                 in_ready;
  tcr_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  tcr_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  tensor_crop_rescale_int8 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Our own copy of the crop settings, kept in step with every register write.
  tcr_mode_t          win_mode  = MODE_CENTRE;
  logic [SHAPE_W-1:0] win_in    = '0;
  logic [SHAPE_W-1:0] win_out   = '0;
  logic [SHAPE_W-1:0] win_off   = '0;
  logic [SCALE_W-1:0] win_scale = SCALE_RESET;

  // Position of the next element inside the input image.
  int col_at  = 0;
  int row_at  = 0;
  int chan_at = 0;

  // Rescaled elements that the block still owes us, oldest first.
  tcr_out_t pending_crops[$];

  int n_items    = 0;
  int n_results  = 0;
  int n_errors   = 0;
  int n_settings = 0;
  int n_cycles   = 0;

  // Sender and receiver idling controls. The sender flag is only used by the test
  // process itself; the receiver ones are driven with nonblocking writes so that the
  // receiver process never races the test process for them.
  bit   tx_gaps_on   = 1'b1;
  logic rx_stalls_on = 1'b1;
  int   rx_hold_len  = 0;

  // Part 0 is the width, 1 the height and 2 the channel count.
  function automatic int dim_of(logic [SHAPE_W-1:0] packed_dims, int part);
    return int'(packed_dims[part*DIMW +: DIMW]);
  endfunction

  function automatic logic [SHAPE_W-1:0] pack3(int c, int h, int w);
    return {DIMW'(c), DIMW'(h), DIMW'(w)};
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Samples lean toward the int8 limits and toward tiny values, where truncation
  // toward zero and saturation are easiest to get wrong.
  function automatic logic signed [7:0] any_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return -8'sd128;
    if (r == 1) return 8'sd127;
    if (r == 2) return 8'($urandom_range(0, 6) - 3);
    return 8'($urandom);
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return SCALE_RESET;
    if (r < 7) return SCALE_W'($urandom_range(0, 24'h01FFFF));
    return SCALE_W'($urandom);
  endfunction

  // Places one accepted element in the image, decides whether it falls inside the crop
  // window and, if so, queues the rescaled value that must come out for it.
  function automatic void crop_and_rescale(tcr_in_t item);
    int iw, ih, ic, ow, oh, oc;
    int offw, offh, offc, endw, endh, endc;
    bit fits, kept;
    longint prod, quot;
    tcr_out_t res;

    if (item.start_req) begin
      col_at  = 0;
      row_at  = 0;
      chan_at = 0;
    end

    iw = dim_of(win_in, 0);
    ih = dim_of(win_in, 1);
    ic = dim_of(win_in, 2);
    ow = dim_of(win_out, 0);
    oh = dim_of(win_out, 1);
    oc = dim_of(win_out, 2);
    offc = 0;
    fits = 1'b1;

    // The centred window needs to fit before its offsets mean anything; the offset
    // modes take their start from the register, and only the checked one insists that
    // the whole window lies inside the input.
    if (win_mode == MODE_CENTRE) begin
      fits = (oh <= ih) && (ow <= iw);
      offh = fits ? (ih - oh) / 2 : 0;
      offw = fits ? (iw - ow) / 2 : 0;
    end else begin
      offh = dim_of(win_off, 1);
      offw = dim_of(win_off, 0);
      if (win_mode == MODE_CHAN_OFFSET) offc = dim_of(win_off, 2);
      if (win_mode == MODE_OFFSET_CHK) fits = (offh + oh <= ih) && (offw + ow <= iw);
    end

    // Whatever reaches past the input is clipped away.
    endw = (offw + ow < iw) ? offw + ow : iw;
    endh = (offh + oh < ih) ? offh + oh : ih;
    endc = (offc + oc < ic) ? offc + oc : ic;

    kept = fits && col_at >= offw && col_at < endw && row_at >= offh && row_at < endh &&
           chan_at >= offc && chan_at < endc;

    if (kept) begin
      prod = longint'($signed(item.sample)) * longint'(win_scale);
      quot = (prod < 0) ? -((-prod) >> 16) : (prod >> 16);
      if (quot > 127) quot = 127;
      if (quot < -128) quot = -128;
      res.cropped       = 8'(quot);
      res.end_of_window = (col_at == endw - 1) && (row_at == endh - 1) &&
                          (chan_at == endc - 1);
      pending_crops.push_back(res);
    end

    // Raster advance; a zero dimension simply rolls over on every element.
    if (col_at + 1 >= iw) begin
      col_at = 0;
      if (row_at + 1 >= ih) begin
        row_at = 0;
        chan_at = (chan_at + 1 >= ic) ? 0 : chan_at + 1;
      end else begin
        row_at = row_at + 1;
      end
    end else begin
      col_at = col_at + 1;
    end
  endfunction

  // One register write per clock edge. The caller lowers cfg_we after the last one, so
  // the enable stays high across back-to-back writes without being toggled in a step.
  task automatic cfg_write(tcr_cfg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_MODE:        win_mode  = tcr_mode_t'(data[1:0]);
      CFG_IN_SHAPE:    win_in    = data[SHAPE_W-1:0];
      CFG_OUT_SHAPE:   win_out   = data[SHAPE_W-1:0];
      CFG_CROP_OFFSET: win_off   = data[SHAPE_W-1:0];
      CFG_SCALE_RATIO: win_scale = data[SCALE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Programs a complete crop setting. Only called while the block is idle.
  task automatic set_window(tcr_mode_t md, logic [SHAPE_W-1:0] ins, logic [SHAPE_W-1:0] outs,
                            logic [SHAPE_W-1:0] offs, logic [SCALE_W-1:0] scl);
    cfg_write(CFG_MODE, CFG_W'(md));
    cfg_write(CFG_IN_SHAPE, ins);
    cfg_write(CFG_OUT_SHAPE, outs);
    cfg_write(CFG_CROP_OFFSET, offs);
    cfg_write(CFG_SCALE_RATIO, CFG_W'(scl));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Offers one element and returns at the edge where it is taken. Valid stays high
  // into the next call when there is no gap, so back-to-back items see no bubble.
  task automatic send_item(logic signed [7:0] smp, logic mark);
    int gap;
    tcr_in_t item;
    item.sample    = smp;
    item.start_req = mark;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    crop_and_rescale(item);
    n_items++;
  endtask

  task automatic send_image(int len, logic mark);
    for (int k = 0; k < len; k++) send_item(any_sample(), mark && (k == 0));
  endtask

  // Stops offering, waits for every owed element and then waits on for strays, since
  // elements outside the window leave nothing behind to wait for.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_crops.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Out of reset all shapes are zero, so no position is inside the input.
  task automatic test_reset_state();
    send_item(-8'sd7, 1'b1);
    settle();
  endtask

  // A full-frame window exercises the multiply: saturation at both ends with the
  // largest ratio, then truncation toward zero with one half. The second row of items
  // carries no start mark and relies on the counters wrapping back to the origin.
  task automatic test_rescale_limits();
    set_window(MODE_OFFSET_UNCH, pack3(1, 1, 4), pack3(1, 1, 4), '0, '1);
    send_item(8'sd127, 1'b1);
    send_item(-8'sd128, 1'b0);
    send_item(8'sd1, 1'b0);
    send_item(-8'sd1, 1'b0);
    settle();
    set_window(MODE_OFFSET_UNCH, pack3(1, 1, 4), pack3(1, 1, 4), '0, 24'h008000);
    send_item(-8'sd1, 1'b0);
    send_item(8'sd3, 1'b0);
    send_item(-8'sd3, 1'b0);
    send_item(-8'sd128, 1'b0);
    settle();
  endtask

  // A 2x3 image with a 2x1 window centred on the middle column. The offset register
  // holds something else on purpose: the centred mode must ignore it.
  task automatic test_centre_crop();
    set_window(MODE_CENTRE, pack3(1, 2, 3), pack3(1, 2, 1), pack3(0, 1, 2), SCALE_RESET);
    for (int k = 0; k < 6; k++) send_item(8'(10 + k), k == 0);
    settle();
  endtask

  // Windows that do not fit must suppress the whole image, in the centred mode and in
  // the checked offset mode alike.
  task automatic test_fit_check();
    set_window(MODE_CENTRE, pack3(1, 1, 2), pack3(1, 1, 3), '0, SCALE_RESET);
    send_item(8'sd40, 1'b1);
    settle();
    set_window(MODE_OFFSET_CHK, pack3(1, 1, 2), pack3(1, 1, 2), pack3(0, 0, 1), SCALE_RESET);
    send_item(8'sd41, 1'b1);
    send_item(8'sd42, 1'b0);
    settle();
  endtask

  // Channel offset with a window that runs past both the last channel and the last
  // column: only the final element survives, doubled into saturation and marked last.
  task automatic test_channel_offset();
    set_window(MODE_CHAN_OFFSET, pack3(2, 1, 2), pack3(2, 1, 2), pack3(1, 0, 1), 24'h020000);
    send_item(8'sd50, 1'b1);
    send_item(8'sd60, 1'b0);
    send_item(8'sd70, 1'b0);
    send_item(8'sd80, 1'b0);
    settle();
  endtask

  // Every element is kept while the receiver holds off for a long stretch, so the
  // internal queue fills and the block has to push back on its input.
  task automatic test_backpressure();
    set_window(MODE_OFFSET_UNCH, pack3(1, 4, 8), pack3(1, 4, 8), '0, SCALE_RESET);
    tx_gaps_on = 1'b0;
    rx_hold_len <= 200;
    send_image(32, 1'b1);
    send_image(32, 1'b1);
    settle();
    tx_gaps_on = 1'b1;
  endtask

  // Random crop settings on small images, each followed by a few whole images with
  // random content. A few images are cut short or sent without a start mark, and some
  // loose items with random marks follow. Every sixth setting pushes the registers to
  // their limits instead.
  task automatic test_random_images();
    int first, phase, ic, ih, iw, n, r;
    tcr_mode_t md;
    logic [SHAPE_W-1:0] ins, outs, offs;
    first = n_items;
    phase = 0;
    while (n_items - first < 880) begin
      phase++;
      md = tcr_mode_t'($urandom_range(0, 3));
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_stalls_on <= ($urandom_range(0, 3) != 0);
      if (phase % 6 == 0) begin
        r = $urandom_range(0, 2);
        ins = (r == 0) ? '1 : (r == 1) ? pack3(1, 1, 4095) : pack3(2, 2, 4);
        outs = $urandom_range(0, 1) ? '1 : pack3(1, 1, 4095);
        r = $urandom_range(0, 2);
        offs = (r == 0) ? '1 : (r == 1) ? '0 : pack3(0, 0, 3);
        set_window(md, ins, outs, offs, pick_scale());
        repeat (24) send_item(any_sample(), $urandom_range(0, 7) == 0);
      end else begin
        ic = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 3);
        ih = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 5);
        iw = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
        outs = pack3($urandom_range(0, ic + 1), $urandom_range(0, ih + 1),
                     $urandom_range(0, iw + 1));
        offs = pack3($urandom_range(0, ic), $urandom_range(0, ih), $urandom_range(0, iw));
        set_window(md, pack3(ic, ih, iw), outs, offs, pick_scale());
        n = ic * ih * iw;
        if (n == 0) n = 6;
        repeat ($urandom_range(1, 3)) begin
          r = $urandom_range(0, 9);
          if (r == 0) send_image($urandom_range(1, n), 1'b1);
          else send_image(n, r != 1);
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_item(any_sample(), $urandom_range(0, 1) == 1);
        end
      end
      settle();
    end
    rx_stalls_on <= 1'b1;
  endtask

  // Receiver: short runs of ready broken by stalls of random length, a steady ready
  // when stalls are switched off, and a long hold-off whenever one is requested.
  initial begin
    int hold_left, run_left, stall_left;
    logic rdy;
    hold_left  = 0;
    run_left   = 0;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        hold_left = rx_hold_len;
        rx_hold_len <= 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!rx_stalls_on) begin
        rdy = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        run_left   = $urandom_range(0, 12);
        stall_left = pick_gap();
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // Every result taken by the receiver is matched against the oldest owed element.
  always @(posedge clk) begin
    tcr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_crops.size() == 0) begin
        n_errors++;
        $display("%0d ns: result with nothing owed: cropped %0d, end_of_window %0b",
                 $time, out_data.cropped, out_data.end_of_window);
      end else begin
        want = pending_crops.pop_front();
        n_results++;
        if (out_data.cropped !== want.cropped) begin
          n_errors++;
          $display("%0d ns: cropped expected %0d, got %0d", $time, want.cropped,
                   out_data.cropped);
        end
        if (out_data.end_of_window !== want.end_of_window) begin
          n_errors++;
          $display("%0d ns: end_of_window expected %0b, got %0b", $time,
                   want.end_of_window, out_data.end_of_window);
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("%0d ns: gave up after %0d cycles, %0d results still owed", $time,
               n_cycles, pending_crops.size());
      $display("tensor_crop_rescale_int8 regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_MODE;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_rescale_limits();
    test_centre_crop();
    test_fit_check();
    test_channel_offset();
    test_backpressure();
    test_random_images();

    // Give any stray result time to show up before the verdict.
    repeat (20) @(posedge clk);
    if (pending_crops.size() != 0) begin
      n_errors++;
      $display("%0d ns: %0d results never arrived", $time, pending_crops.size());
    end
    $display("Sent %0d elements and checked %0d cropped results over %0d window settings,",
             n_items, n_results, n_settings);
    $display("covering all four crop modes, scale and size limits and a long output stall.");
    if (n_errors == 0) begin
      $display("tensor_crop_rescale_int8 regression: pass");
    end else begin
      $display("tensor_crop_rescale_int8 regression: fail");
    end
    $finish;
  end

endmodule
